>>> hdl/assert_macros.svh
// Assertion macros shared by the histogram table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

`define ASSERT_ALWAYS(lbl, c, r, expr) \
	lbl: assert property (@(posedge c) disable iff (!r) (expr)) \
		else $error("assertion failed: invariant");

`define ASSERT_IMPLY(lbl, c, r, ante, cons) \
	lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");

`define ASSERT_NEXT(lbl, c, r, ante, cons) \
	lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");

`else

`define ASSERT_ALWAYS(lbl, c, r, expr)
`define ASSERT_IMPLY(lbl, c, r, ante, cons)
`define ASSERT_NEXT(lbl, c, r, ante, cons)

`endif

`endif

>>> hdl/sht_pkg.sv
// Shared widths, types and result codes of the sample histogram table.
package sht_pkg;

	localparam int KEY_W    = 64;
	localparam int CNT_W    = 32;
	localparam int SLOT_W   = 6;
	localparam int IDX_W    = 6;
	localparam int STATUS_W = 3;
	localparam int MODE_W   = 2;
	localparam int PRIV_W   = 2;
	localparam int ENTRY_W  = KEY_W + CNT_W;

	localparam logic [STATUS_W-1:0] ST_HIT         = 3'd0;
	localparam logic [STATUS_W-1:0] ST_NEW         = 3'd1;
	localparam logic [STATUS_W-1:0] ST_DROP        = 3'd2;
	localparam logic [STATUS_W-1:0] ST_OFF         = 3'd3;
	localparam logic [STATUS_W-1:0] ST_CLEARED     = 3'd4;
	localparam logic [STATUS_W-1:0] ST_READ_OK     = 3'd5;
	localparam logic [STATUS_W-1:0] ST_READ_UNUSED = 3'd6;

	typedef logic [KEY_W-1:0] key_t;
	typedef logic [CNT_W-1:0] cnt_t;

	typedef struct packed {
		key_t key;
		cnt_t cnt;
	} entry_t;

endpackage

>>> hdl/sht_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
module sht_ram #(
	parameter int WIDTH = 96,
	parameter int DEPTH = 64,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hdl/sample_histogram_table.sv
// Sampling profiler histogram: function and process tables held in RAM.
//
// Requests arrive on the input channel (in_valid / in_stall) and each one
// produces exactly one result on the output channel (out_valid / out_stall).
// A sample request looks up its key by scanning the used entries of the
// selected table, one RAM read per cycle, then writes the bumped or new
// entry back. A read request passes through the S_RDAT state, which loads
// the entry from RAM, before S_RESP; an unused read index, a clear and a
// disabled sample go from S_IDLE straight to S_RESP. One request is
// processed at a time; the next request is taken in the cycle after the
// previous result has been loaded into the output register.
// When the receiver stalls, the result is held unchanged in the output
// register, and a further finished result waits until that one is taken.
// Reset clears the used counts, both totals and the enable register; table
// RAM contents are not cleared and entries above the used count are never
// returned. The enable register sits at byte address 0 of the APB port.
`include "assert_macros.svh"

module sample_histogram_table
	import sht_pkg::*;
#(
	parameter int FUNCTION_ENTRIES = 64,
	parameter int PROCESS_ENTRIES  = 16
) (
	input  logic                clk,
	input  logic                arst_n,

	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready,

	input  logic                in_valid,
	output logic                in_stall,
	input  logic [MODE_W-1:0]   mode,
	input  logic [PRIV_W-1:0]   privilege_level,
	input  logic [KEY_W-1:0]    sample_address,
	input  logic                symbol_found,
	input  logic [KEY_W-1:0]    symbol_offset,
	input  logic [KEY_W-1:0]    process_tag,
	input  logic                read_table,
	input  logic [IDX_W-1:0]    read_index,

	output logic                out_valid,
	input  logic                out_stall,
	output logic [STATUS_W-1:0] status,
	output logic [KEY_W-1:0]    entry_key,
	output logic [CNT_W-1:0]    entry_count,
	output logic [SLOT_W-1:0]   entry_slot,
	output logic [CNT_W-1:0]    function_total,
	output logic [CNT_W-1:0]    process_total
);

	localparam int FAW  = (FUNCTION_ENTRIES > 1) ? $clog2(FUNCTION_ENTRIES) : 1;
	localparam int PAW  = (PROCESS_ENTRIES > 1) ? $clog2(PROCESS_ENTRIES) : 1;
	localparam int FUW  = $clog2(FUNCTION_ENTRIES + 1);
	localparam int PUW  = $clog2(PROCESS_ENTRIES + 1);
	localparam int CW   = (FUW > PUW) ? FUW : PUW;
	localparam int CMPW = (CW > IDX_W) ? CW : IDX_W;

	localparam logic              REG_ENABLE  = 1'b0;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
	localparam int                MODE_READ_B = 1;
	localparam logic [PRIV_W-1:0] PRIV_KERNEL = 2'd0;

	typedef enum logic [1:0] {S_IDLE, S_SCAN, S_RDAT, S_RESP} state_t;

	state_t                state_q;
	logic                  enable_q;
	logic [FUW-1:0]        f_used_q;
	logic [PUW-1:0]        p_used_q;
	cnt_t                  fsum_q;
	cnt_t                  psum_q;
	logic                  proc_q;
	key_t                  key_q;
	logic [CW-1:0]         lim_q;
	logic [CW-1:0]         rd_idx_q;
	logic                  chk_s1;
	logic [CW-1:0]         chk_idx_s1;
	logic [STATUS_W-1:0]   res_status_q;
	key_t                  res_key_q;
	cnt_t                  res_cnt_q;
	logic [SLOT_W-1:0]     res_slot_q;
	logic                  out_valid_q;

	entry_t                f_rd;
	entry_t                p_rd;
	entry_t                rd_entry;
	entry_t                wr_entry;
	logic                  in_accept;
	logic                  scan_more;
	logic                  hit;
	logic                  miss;
	logic                  full;
	logic                  do_write;
	logic                  f_we;
	logic                  p_we;
	logic [CW-1:0]         wr_idx;
	logic [CW-1:0]         cap;
	logic [FAW-1:0]        f_raddr;
	logic [PAW-1:0]        p_raddr;
	key_t                  smp_key;
	logic [CMPW-1:0]       rd_lim;
	logic                  rd_ok;
	logic                  cfg_wr;
	logic                  res_load;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = (paddr[2] == REG_ENABLE) ? {31'b0, enable_q} : 32'b0;

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign res_load  = (state_q == S_RESP) && (!out_valid_q || !out_stall);

	assign smp_key  = symbol_found ? (sample_address - symbol_offset) : sample_address;
	assign rd_lim   = read_table ? CMPW'(p_used_q) : CMPW'(f_used_q);
	assign rd_ok    = CMPW'(read_index) < rd_lim;

	// The registered RAM output always belongs to the entry addressed in the previous cycle.
	assign rd_entry  = proc_q ? p_rd : f_rd;
	assign scan_more = rd_idx_q < lim_q;
	assign hit       = chk_s1 && (rd_entry.key == key_q);
	assign miss      = !hit && !scan_more;
	assign cap       = proc_q ? CW'(PROCESS_ENTRIES) : CW'(FUNCTION_ENTRIES);
	assign full      = (lim_q == cap);
	assign do_write  = (state_q == S_SCAN) && (hit || (miss && !full));
	assign f_we      = do_write && !proc_q;
	assign p_we      = do_write && proc_q;
	assign wr_idx    = hit ? chk_idx_s1 : lim_q;

	always_comb begin
		wr_entry.key = key_q;
		wr_entry.cnt = hit ? (rd_entry.cnt + CNT_W'(1)) : CNT_W'(1);
		if (state_q == S_IDLE) begin
			f_raddr = FAW'(read_index);
			p_raddr = PAW'(read_index);
		end else begin
			f_raddr = FAW'(rd_idx_q);
			p_raddr = PAW'(rd_idx_q);
		end
	end

	sht_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (FUNCTION_ENTRIES)
	) u_func_ram (
		.clk   (clk),
		.we    (f_we),
		.waddr (FAW'(wr_idx)),
		.wdata (wr_entry),
		.raddr (f_raddr),
		.rdata (f_rd)
	);

	sht_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (PROCESS_ENTRIES)
	) u_proc_ram (
		.clk   (clk),
		.we    (p_we),
		.waddr (PAW'(wr_idx)),
		.wdata (wr_entry),
		.raddr (p_raddr),
		.rdata (p_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			enable_q       <= 1'b0;
			f_used_q       <= '0;
			p_used_q       <= '0;
			fsum_q         <= '0;
			psum_q         <= '0;
			proc_q         <= 1'b0;
			key_q          <= '0;
			lim_q          <= '0;
			rd_idx_q       <= '0;
			chk_s1         <= 1'b0;
			chk_idx_s1     <= '0;
			res_status_q   <= ST_HIT;
			res_key_q      <= '0;
			res_cnt_q      <= '0;
			res_slot_q     <= '0;
			out_valid_q    <= 1'b0;
			status         <= ST_HIT;
			entry_key      <= '0;
			entry_count    <= '0;
			entry_slot     <= '0;
			function_total <= '0;
			process_total  <= '0;
		end else begin
			if (cfg_wr && (paddr[2] == REG_ENABLE)) begin
				enable_q <= pwdata[0];
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_accept) begin
						chk_s1     <= 1'b0;
						rd_idx_q   <= '0;
						res_key_q  <= '0;
						res_cnt_q  <= '0;
						res_slot_q <= (mode[MODE_READ_B] && rd_ok) ?
							SLOT_W'(read_index) : '0;
						if (mode[MODE_READ_B]) begin
							proc_q <= read_table;
							if (rd_ok) begin
								state_q <= S_RDAT;
							end else begin
								res_status_q <= ST_READ_UNUSED;
								state_q      <= S_RESP;
							end
						end else if (mode == MODE_CLEAR) begin
							f_used_q     <= '0;
							p_used_q     <= '0;
							fsum_q       <= '0;
							psum_q       <= '0;
							res_status_q <= ST_CLEARED;
							state_q      <= S_RESP;
						end else if (!enable_q) begin
							res_status_q <= ST_OFF;
							state_q      <= S_RESP;
						end else if (privilege_level != PRIV_KERNEL) begin
							proc_q  <= 1'b1;
							key_q   <= process_tag;
							psum_q  <= psum_q + CNT_W'(1);
							lim_q   <= CW'(p_used_q);
							state_q <= S_SCAN;
						end else begin
							proc_q  <= 1'b0;
							key_q   <= smp_key;
							fsum_q  <= fsum_q + CNT_W'(1);
							lim_q   <= CW'(f_used_q);
							state_q <= S_SCAN;
						end
					end
				end

				S_SCAN: begin
					res_key_q <= key_q;
					if (hit) begin
						res_status_q <= ST_HIT;
						res_cnt_q    <= rd_entry.cnt + CNT_W'(1);
						res_slot_q   <= SLOT_W'(chk_idx_s1);
						state_q      <= S_RESP;
					end else if (scan_more) begin
						chk_s1     <= 1'b1;
						chk_idx_s1 <= rd_idx_q;
						rd_idx_q   <= rd_idx_q + CW'(1);
					end else begin
						// Every used entry has been compared without a match.
						if (!full) begin
							res_status_q <= ST_NEW;
							res_cnt_q    <= CNT_W'(1);
							res_slot_q   <= SLOT_W'(lim_q);
							if (proc_q) begin
								p_used_q <= p_used_q + PUW'(1);
							end else begin
								f_used_q <= f_used_q + FUW'(1);
							end
						end else begin
							res_status_q <= ST_DROP;
							res_cnt_q    <= '0;
							res_slot_q   <= '0;
						end
						state_q <= S_RESP;
					end
				end

				S_RDAT: begin
					res_status_q <= ST_READ_OK;
					res_key_q    <= rd_entry.key;
					res_cnt_q    <= rd_entry.cnt;
					state_q      <= S_RESP;
				end

				S_RESP: begin
					if (res_load) begin
						status         <= res_status_q;
						entry_key      <= res_key_q;
						entry_count    <= res_cnt_q;
						entry_slot     <= res_slot_q;
						function_total <= fsum_q;
						process_total  <= psum_q;
						state_q        <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_ALWAYS(a_one_table_write, clk, arst_n, !(f_we && p_we))
	`ASSERT_NEXT(a_write_ends_scan, clk, arst_n, f_we || p_we, state_q == S_RESP)
	`ASSERT_ALWAYS(a_func_used_cap, clk, arst_n, f_used_q <= FUW'(FUNCTION_ENTRIES))
	`ASSERT_IMPLY(a_check_in_range, clk, arst_n, state_q == S_SCAN && chk_s1, chk_idx_s1 < lim_q)
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_accept, in_stall)

endmodule

>>> verif/sample_histogram_table_tb.sv
// Self-checking testbench for the sample histogram table: directed and random requests.
module sample_histogram_table_tb;
	import sht_pkg::*;

	localparam int FN_DEPTH = 64;
	localparam int PR_DEPTH = 16;
	localparam int HOLD_CYCLES = 400;

	localparam logic [2:0] REG_ENABLE = 3'd0;

	localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_CLEAR  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_READ   = 2'd2;
	localparam logic [MODE_W-1:0] MODE_UNDEF  = 2'd3;

	localparam logic TABLE_FUNCTION = 1'b0;
	localparam logic TABLE_PROCESS  = 1'b1;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [PRIV_W-1:0] privilege_level;
		key_t              sample_address;
		logic              symbol_found;
		key_t              symbol_offset;
		key_t              process_tag;
		logic              read_table;
		logic [IDX_W-1:0]  read_index;
	} request_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		key_t                key;
		cnt_t                count;
		logic [SLOT_W-1:0]   slot;
		cnt_t                fn_total;
		cnt_t                pr_total;
	} outcome_t;

	logic                clk;
	logic                arst_n = 1'b0;
	logic                psel = 1'b0;
	logic                penable = 1'b0;
	logic                pwrite = 1'b0;
	logic [2:0]          paddr = '0;
	logic [31:0]         pwdata = '0;
	logic [31:0]         prdata;
	logic                pready;
	logic                in_valid = 1'b0;
	logic                in_stall;
	logic [MODE_W-1:0]   mode = '0;
	logic [PRIV_W-1:0]   privilege_level = '0;
	logic [KEY_W-1:0]    sample_address = '0;
	logic                symbol_found = 1'b0;
	logic [KEY_W-1:0]    symbol_offset = '0;
	logic [KEY_W-1:0]    process_tag = '0;
	logic                read_table = 1'b0;
	logic [IDX_W-1:0]    read_index = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [KEY_W-1:0]    entry_key;
	logic [CNT_W-1:0]    entry_count;
	logic [SLOT_W-1:0]   entry_slot;
	logic [CNT_W-1:0]    function_total;
	logic [CNT_W-1:0]    process_total;

	// Shadow copy of the histogram state.
	key_t fn_keys [FN_DEPTH];
	cnt_t fn_counts [FN_DEPTH];
	int   fn_used = 0;
	key_t pr_keys [PR_DEPTH];
	cnt_t pr_counts [PR_DEPTH];
	int   pr_used = 0;
	cnt_t fn_total = '0;
	cnt_t pr_total = '0;
	logic counting_on = 1'b0;

	outcome_t pending_outcomes [$];
	int       mismatches = 0;

	bit offer_on = 1'b0;
	bit gaps_on = 1'b1;
	int burst_left = 4;
	bit receiver_stalls = 1'b1;
	bit hold_req = 1'b0;

	key_t fn_pool [24];
	key_t pr_pool [20];

	sample_histogram_table #(
		.FUNCTION_ENTRIES(FN_DEPTH),
		.PROCESS_ENTRIES(PR_DEPTH)
	) dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5000000;
		$display("RESULT: ERROR");
		$finish;
	end

	function automatic key_t rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic outcome_t histogram_outcome(request_t r);
		outcome_t o;
		key_t     k;
		int       n;
		int       hit;
		int       i;
		bit       to_proc;
		o = '0;
		if (r.mode[1]) begin
			n = r.read_table ? pr_used : fn_used;
			if (int'(r.read_index) < n) begin
				o.status = ST_READ_OK;
				o.slot = r.read_index;
				if (r.read_table) begin
					o.key = pr_keys[r.read_index];
					o.count = pr_counts[r.read_index];
				end else begin
					o.key = fn_keys[r.read_index];
					o.count = fn_counts[r.read_index];
				end
			end else begin
				o.status = ST_READ_UNUSED;
			end
		end else if (r.mode == MODE_CLEAR) begin
			fn_used = 0;
			pr_used = 0;
			fn_total = '0;
			pr_total = '0;
			o.status = ST_CLEARED;
		end else if (!counting_on) begin
			o.status = ST_OFF;
		end else begin
			to_proc = (r.privilege_level != 0);
			if (to_proc) begin
				k = r.process_tag;
				pr_total++;
				n = pr_used;
			end else begin
				k = r.symbol_found ? r.sample_address - r.symbol_offset : r.sample_address;
				fn_total++;
				n = fn_used;
			end
			hit = -1;
			for (i = 0; i < n; i++) begin
				if (hit < 0 && (to_proc ? pr_keys[i] : fn_keys[i]) == k)
					hit = i;
			end
			o.key = k;
			if (hit >= 0) begin
				o.status = ST_HIT;
				o.slot = SLOT_W'(hit);
				if (to_proc) begin
					pr_counts[hit]++;
					o.count = pr_counts[hit];
				end else begin
					fn_counts[hit]++;
					o.count = fn_counts[hit];
				end
			end else if (n < (to_proc ? PR_DEPTH : FN_DEPTH)) begin
				o.status = ST_NEW;
				o.slot = SLOT_W'(n);
				o.count = 1;
				if (to_proc) begin
					pr_keys[n] = k;
					pr_counts[n] = 1;
					pr_used++;
				end else begin
					fn_keys[n] = k;
					fn_counts[n] = 1;
					fn_used++;
				end
			end else begin
				o.status = ST_DROP;
			end
		end
		o.fn_total = fn_total;
		o.pr_total = pr_total;
		return o;
	endfunction

	// Every field random, so that unused fields toggle too.
	function automatic request_t noise_request();
		request_t r;
		r.mode = MODE_W'($urandom);
		r.privilege_level = PRIV_W'($urandom);
		r.sample_address = rand64();
		r.symbol_found = 1'($urandom);
		r.symbol_offset = rand64();
		r.process_tag = rand64();
		r.read_table = 1'($urandom);
		r.read_index = IDX_W'($urandom);
		return r;
	endfunction

	function automatic request_t make_sample(bit to_proc, key_t k);
		request_t r;
		r = noise_request();
		r.mode = MODE_SAMPLE;
		if (to_proc) begin
			r.privilege_level = PRIV_W'($urandom_range(1, 3));
			r.process_tag = k;
		end else begin
			r.privilege_level = '0;
			r.sample_address = r.symbol_found ? k + r.symbol_offset : k;
		end
		return r;
	endfunction

	function automatic request_t read_request(logic tbl, logic [IDX_W-1:0] idx);
		request_t r;
		r = noise_request();
		r.mode = MODE_READ;
		r.read_table = tbl;
		r.read_index = idx;
		return r;
	endfunction

	task automatic compare_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	task automatic offer_request(input request_t r);
		in_valid        <= 1'b1;
		mode            <= r.mode;
		privilege_level <= r.privilege_level;
		sample_address  <= r.sample_address;
		symbol_found    <= r.symbol_found;
		symbol_offset   <= r.symbol_offset;
		process_tag     <= r.process_tag;
		read_table      <= r.read_table;
		read_index      <= r.read_index;
		offer_on = 1'b1;
		@(posedge clk);
		while (in_stall !== 1'b0) @(posedge clk);
		pending_outcomes.push_back(histogram_outcome(r));
		if (gaps_on) begin
			burst_left--;
			if (burst_left <= 0) begin
				in_valid <= 1'b0;
				offer_on = 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				burst_left = $urandom_range(1, 12);
			end
		end
	endtask

	task automatic wait_drain();
		if (offer_on) begin
			in_valid <= 1'b0;
			offer_on = 1'b0;
		end
		while (pending_outcomes.size() != 0) @(posedge clk);
	endtask

	// Write the enable register, then read it back. Called only while the block is idle.
	task automatic write_enable_reg(logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= REG_ENABLE;
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		counting_on = value[0];
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1) @(posedge clk);
		compare_field("enable readback", 64'(counting_on), 64'(prdata));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic test_disabled();
		request_t r;
		offer_request(make_sample(1'b0, rand64()));
		offer_request(make_sample(1'b1, rand64()));
		offer_request(read_request(TABLE_FUNCTION, '0));
		offer_request(read_request(TABLE_PROCESS, '0));
		r = read_request(TABLE_PROCESS, '1);
		r.mode = MODE_UNDEF;
		offer_request(r);
		r = noise_request();
		r.mode = MODE_CLEAR;
		offer_request(r);
		r = make_sample(1'b1, '1);
		r.privilege_level = '1;
		offer_request(r);
		wait_drain();
	endtask

	task automatic test_directed();
		request_t r;
		write_enable_reg(32'd1);
		r = make_sample(1'b0, '0);
		r.symbol_found = 1'b0;
		r.sample_address = '0;
		offer_request(r);
		r.sample_address = '1;
		offer_request(r);
		// Address below the offset wraps around to the all-ones key.
		r.symbol_found = 1'b1;
		r.sample_address = 64'd5;
		r.symbol_offset = 64'd6;
		offer_request(r);
		r.sample_address = '1;
		r.symbol_offset = '1;
		offer_request(r);
		r.sample_address = 64'h8000_0000_0000_0000;
		r.symbol_offset = '0;
		offer_request(r);
		r = make_sample(1'b1, '0);
		r.privilege_level = 2'd1;
		offer_request(r);
		r.privilege_level = 2'd2;
		offer_request(r);
		r.privilege_level = 2'd3;
		r.process_tag = '1;
		offer_request(r);
		offer_request(r);
		offer_request(read_request(TABLE_FUNCTION, 6'd0));
		offer_request(read_request(TABLE_FUNCTION, 6'd2));
		offer_request(read_request(TABLE_FUNCTION, '1));
		offer_request(read_request(TABLE_PROCESS, 6'd1));
		offer_request(read_request(TABLE_PROCESS, 6'd2));
		r = read_request(TABLE_PROCESS, 6'd0);
		r.mode = MODE_UNDEF;
		offer_request(r);
		r = noise_request();
		r.mode = MODE_CLEAR;
		offer_request(r);
		offer_request(read_request(TABLE_FUNCTION, 6'd0));
		offer_request(make_sample(1'b0, rand64()));
		wait_drain();
	endtask

	task automatic test_table_full();
		request_t r;
		key_t     k;
		int       i;
		r = noise_request();
		r.mode = MODE_CLEAR;
		offer_request(r);
		// The top bits make every key distinct, so each table fills up and the two extra samples are dropped.
		for (i = 0; i < PR_DEPTH + 2; i++) begin
			k = rand64();
			k[63:48] = 16'(i + 1);
			offer_request(make_sample(1'b1, k));
			if (i == 0)
				pr_pool[0] = k;
		end
		offer_request(make_sample(1'b1, pr_pool[0]));
		for (i = 0; i < FN_DEPTH + 2; i++) begin
			k = rand64();
			k[63:48] = 16'(i + 1);
			offer_request(make_sample(1'b0, k));
			if (i == FN_DEPTH - 1)
				fn_pool[0] = k;
		end
		offer_request(make_sample(1'b0, fn_pool[0]));
		offer_request(read_request(TABLE_FUNCTION, 6'd63));
		offer_request(read_request(TABLE_PROCESS, 6'd15));
		offer_request(read_request(TABLE_PROCESS, 6'd16));
		r = noise_request();
		r.mode = MODE_CLEAR;
		offer_request(r);
		wait_drain();
	endtask

	// The receiver holds off while requests keep coming, so the input stalls.
	task automatic test_backpressure();
		int i;
		gaps_on = 1'b0;
		hold_req = 1'b1;
		for (i = 0; i < 12; i++)
			offer_request(make_sample(1'($urandom), rand64()));
		wait_drain();
		gaps_on = 1'b1;
	endtask

	task automatic test_random_traffic();
		logic [31:0] settings [6];
		int          lengths [6];
		request_t    r;
		int          pick;
		int          n;
		int          p;
		int          j;
		settings = '{32'd1, 32'hFFFF_FFFF, 32'd0, 32'd1, 32'hFFFF_FFFE, 32'd1};
		lengths = '{70, 70, 15, 70, 15, 80};
		fn_pool[0] = '0;
		fn_pool[1] = '1;
		for (j = 2; j < 24; j++)
			fn_pool[j] = rand64();
		pr_pool[0] = '0;
		pr_pool[1] = '1;
		for (j = 2; j < 20; j++)
			pr_pool[j] = rand64();
		for (p = 0; p < 6; p++) begin
			wait_drain();
			write_enable_reg(settings[p]);
			gaps_on = (p % 3 != 1);
			receiver_stalls = (p != 3);
			for (j = 0; j < lengths[p]; j++) begin
				pick = $urandom_range(0, 199);
				if (pick < 3) begin
					r = noise_request();
					r.mode = MODE_CLEAR;
				end else if (pick < 50) begin
					r = noise_request();
					r.mode = (pick < 10) ? MODE_UNDEF : MODE_READ;
					n = r.read_table ? pr_used : fn_used;
					if (n > 0 && $urandom_range(0, 9) < 7)
						r.read_index = IDX_W'($urandom_range(0, n - 1));
				end else if (pick < 125) begin
					r = make_sample(1'b0, ($urandom_range(0, 9) == 0) ? rand64()
						: fn_pool[$urandom_range(0, 23)]);
				end else begin
					r = make_sample(1'b1, pr_pool[$urandom_range(0, 19)]);
				end
				offer_request(r);
			end
		end
		wait_drain();
	endtask

	// Receiver stall pattern: windows of random length, each with its own stall density.
	initial begin : stall_gen
		int window;
		int duty;
		int hold_left;
		window = 0;
		duty = 0;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				if (window == 0) begin
					window = $urandom_range(8, 64);
					case ($urandom_range(0, 3))
						0: duty = 0;
						1: duty = 25;
						2: duty = 50;
						default: duty = 85;
					endcase
					if (!receiver_stalls)
						duty = 0;
				end
				window--;
				out_stall <= ($urandom_range(0, 99) < duty);
			end
		end
	end

	initial begin : result_check
		outcome_t want;
		forever begin
			@(posedge clk);
			if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
				if (pending_outcomes.size() == 0) begin
					$display("%0t: result with no request waiting: status %h key %h",
						$time, status, entry_key);
					mismatches++;
				end else begin
					want = pending_outcomes.pop_front();
					compare_field("status", 64'(want.status), 64'(status));
					compare_field("entry_key", want.key, entry_key);
					compare_field("entry_count", 64'(want.count), 64'(entry_count));
					compare_field("entry_slot", 64'(want.slot), 64'(entry_slot));
					compare_field("function_total", 64'(want.fn_total), 64'(function_total));
					compare_field("process_total", 64'(want.pr_total), 64'(process_total));
				end
			end
		end
	end

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_disabled();
		test_directed();
		test_table_full();
		test_backpressure();
		test_random_traffic();
		wait_drain();
		// A late extra result would show up here.
		repeat (100) @(posedge clk);
		if (mismatches == 0 && pending_outcomes.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

>>> filelist.f
+incdir+hdl
hdl/sht_pkg.sv
hdl/sht_ram.sv
hdl/sample_histogram_table.sv
verif/sample_histogram_table_tb.sv
